### design/pwagc_pkg.sv
// pwagc_pkg: shared widths, register indexes and types for the peak window AGC.
// Used by pwagc_div and peak_window_agc; depends on nothing else.
`default_nettype none

package pwagc_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 15;
   localparam int GAIN_W     = 16;
   localparam int COEFF_W    = 16;
   localparam int FRAC_BITS  = 12;
   localparam int DIVIDEND_W = LEVEL_W + FRAC_BITS;
   localparam int CSR_IDX_W  = 3;

   // Register indexes on the write port
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_LEVEL      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SILENCE_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_GAIN          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_GAIN          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_COEFF      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_COEFF     = 3'd5;

   // Request into the divider
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [LEVEL_W-1:0]    divisor;
   } pwagc_div_req_type;

endpackage

`default_nettype wire

### design/pwagc_div.sv
// pwagc_div: restoring divider, one quotient bit per cycle, for the target gain.
// Depends on pwagc_pkg for widths and the request struct.
`default_nettype none

module pwagc_div (
   input  wire                                 clock,
   input  wire                                 reset,
   input  pwagc_pkg::pwagc_div_req_type        div_req,
   output logic                                div_done,
   output logic [pwagc_pkg::DIVIDEND_W-1:0]    div_quotient
);
   import pwagc_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [LEVEL_W-1:0]    rem_ff, rem_in;
   logic [LEVEL_W-1:0]    dvs_ff, dvs_in;

   logic [LEVEL_W:0]      shifted;
   logic [LEVEL_W+1:0]    trial;

   // One restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[LEVEL_W+1]) begin
            rem_in = trial[LEVEL_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[LEVEL_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

`default_nettype wire

### design/peak_window_agc.sv
// peak_window_agc: peak tracking automatic gain control over framed audio.
// Depends on pwagc_pkg and instantiates pwagc_div.
//
// Use: samples come in on the req_ channel (req_valid/req_ready) one word per
// accepted handshake; req_frame_end marks the last word of a frame, and a frame
// also closes by itself once FRAME_MAX words are held. Gained words leave on the
// rsp_ channel, rsp_out_last on the last word of each frame. Registers are
// written on the csr_ port (csr_we, csr_index, csr_wdata); the user must do so
// only while the block idles, as the block itself does not enforce it. At a
// frame end the block is busy: it stores the frame peak, scans the peak ring,
// checks for silence, runs the bit-serial divider (skipped when silent), then
// clamps and steps the gain through the shared 17x17 multiplier. Each buffered
// word then passes store read, multiply and output load on that same multiplier.
// req_ready is high only while loading; a stalled receiver holds the output
// register and the drain waits. Reset clears the peak ring, fill count, ring
// pointer and gain (unity) and loads register defaults; the frame store needs
// no clearing.
`default_nettype none

module peak_window_agc #(
   parameter int FRAME_MAX     = 64,
   parameter int WINDOW_FRAMES = 10
) (
   input  wire                                     clock,
   input  wire                                     reset,
   // input samples
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire signed [pwagc_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  wire                                     req_frame_end,
   // gained samples
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [pwagc_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic                                    rsp_out_last,
   // register writes
   input  wire                                     csr_we,
   input  wire        [pwagc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire        [pwagc_pkg::GAIN_W-1:0]      csr_wdata
);
   import pwagc_pkg::*;

   localparam int AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
   localparam int CW = $clog2(FRAME_MAX + 1);
   localparam int RW = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
   localparam logic [CW-1:0] FRAME_FULL = CW'(FRAME_MAX);
   localparam logic [RW-1:0] RING_LAST  = RW'(WINDOW_FRAMES - 1);
   localparam int MUL_W  = GAIN_W + 1;
   localparam int PROD_W = 2 * MUL_W;

   // Sequencer codes
   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_RING   = 4'd1;
   localparam logic [3:0] ST_SCAN   = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_CLAMP  = 4'd5;
   localparam logic [3:0] ST_STEP   = 4'd6;
   localparam logic [3:0] ST_UPDATE = 4'd7;
   localparam logic [3:0] ST_READ   = 4'd8;
   localparam logic [3:0] ST_MULT   = 4'd9;
   localparam logic [3:0] ST_EMIT   = 4'd10;

   // Configuration registers
   logic [LEVEL_W-1:0] target_level_ff;
   logic [LEVEL_W-1:0] silence_thr_ff;
   logic [GAIN_W-1:0]  min_gain_ff;
   logic [GAIN_W-1:0]  max_gain_ff;
   logic [COEFF_W-1:0] attack_coeff_ff;
   logic [COEFF_W-1:0] release_coeff_ff;

   // Sequencer and frame state
   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [LEVEL_W-1:0]  peak_ff, peak_in;
   logic [LEVEL_W-1:0]  ring_ff [WINDOW_FRAMES];
   logic [RW-1:0]       ring_ptr_ff, ring_ptr_in;
   logic [RW-1:0]       scan_ff, scan_in;
   logic [LEVEL_W-1:0]  wmax_ff, wmax_in;
   logic [DIVIDEND_W-1:0] target_raw_ff, target_raw_in;
   logic [GAIN_W-1:0]   target_ff, target_in;
   logic                down_ff, down_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Frame store
   logic [SAMPLE_W-1:0] store_mem [FRAME_MAX];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                store_we;

   // Divider hookup
   pwagc_div_req_type     div_req;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;

   // Combinational helpers
   logic [SAMPLE_W-1:0]       abs_sample;
   logic [LEVEL_W-1:0]        mag_sample;
   logic                      frame_close;
   logic [DIVIDEND_W-1:0]     clamp_lo;
   logic [GAIN_W:0]           diff;
   logic [GAIN_W-1:0]         diff_mag;
   logic [COEFF_W-1:0]        coeff_sel;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic [GAIN_W-1:0]         step_mag;
   logic [GAIN_W:0]           gain_sum;
   logic [GAIN_W-1:0]         gain_next;
   logic [GAIN_W-1:0]         gain_lo;
   logic signed [PROD_W-1:0]  prod_biased;
   logic signed [PROD_W-1:0]  quot_out;
   logic signed [SAMPLE_W-1:0] sat_out;
   logic                      emit_last;
   logic                      out_free;

   pwagc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         target_level_ff  <= 15'd16384;
         silence_thr_ff   <= 15'd64;
         min_gain_ff      <= 16'd4096;
         max_gain_ff      <= 16'd40960;
         attack_coeff_ff  <= 16'd6554;
         release_coeff_ff <= 16'd655;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_LEVEL:      target_level_ff  <= csr_wdata[LEVEL_W-1:0];
            REG_SILENCE_THRESHOLD: silence_thr_ff   <= csr_wdata[LEVEL_W-1:0];
            REG_MIN_GAIN:          min_gain_ff      <= csr_wdata;
            REG_MAX_GAIN:          max_gain_ff      <= csr_wdata;
            REG_ATTACK_COEFF:      attack_coeff_ff  <= csr_wdata;
            REG_RELEASE_COEFF:     release_coeff_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input magnitude, with the most negative sample folded to full scale
   always_comb begin
      abs_sample  = req_sample_in[SAMPLE_W-1] ? (~req_sample_in + SAMPLE_W'(1))
                                              : req_sample_in;
      mag_sample  = abs_sample[SAMPLE_W-1] ? {LEVEL_W{1'b1}} : abs_sample[LEVEL_W-1:0];
      frame_close = req_frame_end || (fill_ff + CW'(1) == FRAME_FULL);
   end

   // Gain step arithmetic
   always_comb begin
      clamp_lo  = (target_raw_ff < DIVIDEND_W'(min_gain_ff)) ? DIVIDEND_W'(min_gain_ff)
                                                            : target_raw_ff;
      diff      = {1'b0, target_ff} - {1'b0, gain_ff};
      diff_mag  = diff[GAIN_W] ? (~diff[GAIN_W-1:0] + GAIN_W'(1)) : diff[GAIN_W-1:0];
      coeff_sel = (target_ff < gain_ff) ? attack_coeff_ff : release_coeff_ff;
      step_mag  = prod_ff[2*GAIN_W-1:GAIN_W];
      gain_sum  = {1'b0, gain_ff} + {1'b0, step_mag};
      if (down_ff) begin
         gain_next = (step_mag > gain_ff) ? '0 : (gain_ff - step_mag);
      end else begin
         gain_next = gain_sum[GAIN_W] ? {GAIN_W{1'b1}} : gain_sum[GAIN_W-1:0];
      end
      gain_lo = (gain_next < min_gain_ff) ? min_gain_ff : gain_next;
   end

   // Shared multiplier operands: gain step, or sample times gain
   always_comb begin
      if (state_ff == ST_STEP) begin
         mul_a = {1'b0, coeff_sel};
         mul_b = {1'b0, diff_mag};
      end else begin
         mul_a = {rd_data_ff[SAMPLE_W-1], rd_data_ff};
         mul_b = {1'b0, gain_ff};
      end
   end

   // Scale back by the Q4.12 point toward zero, then saturate
   always_comb begin
      prod_biased = prod_ff[PROD_W-1] ? (prod_ff + PROD_W'((1 << FRAC_BITS) - 1)) : prod_ff;
      quot_out    = prod_biased >>> FRAC_BITS;
      if (quot_out > PROD_W'(32767)) begin
         sat_out = 16'sh7FFF;
      end else if (quot_out < -PROD_W'(32768)) begin
         sat_out = 16'sh8000;
      end else begin
         sat_out = quot_out[SAMPLE_W-1:0];
      end
      emit_last = (CW'(idx_ff) + CW'(1) == fill_ff);
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign store_we  = req_valid && req_ready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      peak_in       = peak_ff;
      ring_ptr_in   = ring_ptr_ff;
      scan_in       = scan_ff;
      wmax_in       = wmax_ff;
      target_raw_in = target_raw_ff;
      target_in     = target_ff;
      down_in       = down_ff;
      gain_in       = gain_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      div_req       = '{start: 1'b0,
                        dividend: {target_level_ff, {FRAC_BITS{1'b0}}},
                        divisor: wmax_ff};
      unique case (state_ff)
         ST_LOAD: begin
            // take a word, track the frame peak
            if (store_we) begin
               fill_in = fill_ff + CW'(1);
               if (mag_sample > peak_ff) peak_in = mag_sample;
               if (frame_close) state_in = ST_RING;
            end
         end
         ST_RING: begin
            // advance the ring pointer; the ring write itself is below
            ring_ptr_in = (ring_ptr_ff == RING_LAST) ? '0 : ring_ptr_ff + RW'(1);
            peak_in     = '0;
            scan_in     = '0;
            wmax_in     = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            // one ring entry per cycle into the running maximum
            if (ring_ff[scan_ff] > wmax_ff) wmax_in = ring_ff[scan_ff];
            if (scan_ff == RING_LAST) begin
               state_in = ST_CHECK;
            end else begin
               scan_in = scan_ff + RW'(1);
            end
         end
         ST_CHECK: begin
            // silent window holds the gain
            if (wmax_ff != '0 && wmax_ff >= silence_thr_ff) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               target_raw_in = DIVIDEND_W'(gain_ff);
               state_in      = ST_CLAMP;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               target_raw_in = div_quotient;
               state_in      = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            // min first, max wins
            target_in = (clamp_lo > DIVIDEND_W'(max_gain_ff)) ? max_gain_ff
                                                              : clamp_lo[GAIN_W-1:0];
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            down_in  = (target_ff < gain_ff);
            prod_in  = mul_a * mul_b;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            gain_in  = (gain_lo > max_gain_ff) ? max_gain_ff : gain_lo;
            idx_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            // store read data lands at this edge
            state_in = ST_MULT;
         end
         ST_MULT: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat_out;
               rsp_last_in   = emit_last;
               if (emit_last) begin
                  fill_in  = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         peak_ff      <= '0;
         ring_ptr_ff  <= '0;
         gain_ff      <= 16'd4096;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         peak_ff      <= peak_in;
         ring_ptr_ff  <= ring_ptr_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Peak ring, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_FRAMES; i++) ring_ff[i] <= '0;
      end else if (state_ff == ST_RING) begin
         ring_ff[ring_ptr_ff] <= peak_ff;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      wmax_ff       <= wmax_in;
      target_raw_ff <= target_raw_in;
      target_ff     <= target_in;
      down_ff       <= down_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Frame store: write on load, registered read at the drain index
   always_ff @(posedge clock) begin
      if (store_we) store_mem[fill_ff[AW-1:0]] <= req_sample_in;
      rd_data_ff <= store_mem[idx_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_out_last   = rsp_last_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FRAME_FULL)
      else $error("frame fill count beyond frame size");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside its wait state");

   a_gain_capped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> gain_ff <= max_gain_ff)
      else $error("gain above max after update");

   a_no_load_while_draining: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !out_free) |=> state_ff == ST_EMIT)
      else $error("drain advanced while output register held");

endmodule

`default_nettype wire
